### hdl/planar_tile_to_rgba4_converter_macros.svh
// Assertion macros for the tile to RGBA4 converter.
`ifndef PLANAR_TILE_TO_RGBA4_CONVERTER_MACROS_SVH
`define PLANAR_TILE_TO_RGBA4_CONVERTER_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define PTR4C_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define PTR4C_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hdl/ptr4c_pkg.sv
// Shared types, constants and the color lookup of the tile converter.
package ptr4c_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned COLOR_W = 16;
	localparam int unsigned IDX_W   = 11;
	localparam int unsigned ADDR_W  = 16;
	localparam int unsigned BLANK_W = 12;
	localparam int unsigned KCNT_W  = 5;

	localparam logic [1:0] CFG_COLOR_ONE   = 2'd0;
	localparam logic [1:0] CFG_COLOR_TWO   = 2'd1;
	localparam logic [1:0] CFG_COLOR_THREE = 2'd2;

	localparam logic [1:0] PIX_CLEAR = 2'd0;
	localparam logic [1:0] PIX_ONE   = 2'd1;
	localparam logic [1:0] PIX_TWO   = 2'd2;
	localparam logic [1:0] PIX_THREE = 2'd3;

	localparam logic [COLOR_W-1:0] COLOR_ONE_RST   = 16'h00ff;
	localparam logic [COLOR_W-1:0] COLOR_TWO_RST   = 16'h0f0f;
	localparam logic [COLOR_W-1:0] COLOR_THREE_RST = 16'hf00f;

	localparam logic [BLANK_W-1:0] BLANK_NONE = 12'hfff;
	localparam logic [KCNT_W-1:0]  KCNT_LAST  = 5'd31;

	// one classified tile request between front and back
	typedef struct packed {
		logic [ADDR_W-1:0]         base;
		logic                      modified;
		logic                      vis;
		logic [BLANK_W-1:0]        blank;
		logic [3:0][WORD_W-1:0]    words;
	} qent_t;

	typedef struct packed {
		logic [COLOR_W-1:0] one;
		logic [COLOR_W-1:0] two;
		logic [COLOR_W-1:0] three;
	} palette_t;

	function automatic logic [COLOR_W-1:0] color_of(input logic [1:0] code,
			input palette_t pal);
		logic [COLOR_W-1:0] c;
		case (code)
			PIX_CLEAR: c = '0;
			PIX_ONE:   c = pal.one;
			PIX_TWO:   c = pal.two;
			PIX_THREE: c = pal.three;
			default:   c = '0;
		endcase
		return c;
	endfunction

endpackage

### hdl/ptr4c_front.sv
// Front end: accepts tiles, keeps the visibility map and the blank-tile finding.
module ptr4c_front import ptr4c_pkg::*; #(
	parameter int unsigned NUM_TILES = 2048
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [IDX_W-1:0]     tile_index,
	input  logic                 modified,
	input  logic                 new_pass,
	input  logic [WORD_W-1:0]    char_word_zero,
	input  logic [WORD_W-1:0]    char_word_one,
	input  logic [WORD_W-1:0]    char_word_two,
	input  logic [WORD_W-1:0]    char_word_three,
	output logic                 push_valid,
	input  logic                 push_ready,
	output qent_t                push_data
);

	localparam int unsigned MAP_AW = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1;
	localparam logic [MAP_AW-1:0] CLR_LAST = MAP_AW'(NUM_TILES - 1);

	logic                 map_q [NUM_TILES];
	logic                 rd_q;
	logic                 clear_q;
	logic [MAP_AW-1:0]    clr_cnt_q;

	logic                 valid_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 mod_s1;
	logic                 newp_s1;
	logic                 wvis_s1;
	logic                 inrange_s1;
	logic [3:0][WORD_W-1:0] words_s1;

	logic                 found_q;
	logic [IDX_W-1:0]     bidx_q;

	logic                 accept;
	logic                 push;
	logic                 in_range;
	logic                 word_vis;
	logic                 map_we;
	logic [MAP_AW-1:0]    map_wa;
	logic                 map_wd;
	logic                 found_eff;
	logic                 vis;
	logic                 found_nxt;
	logic [IDX_W-1:0]     bidx_nxt;

	assign in_range = {1'b0, tile_index} < (IDX_W + 1)'(NUM_TILES);
	assign word_vis = |{char_word_zero, char_word_one, char_word_two, char_word_three};
	assign push     = valid_s1 && push_ready;
	assign in_ready = !clear_q && (!valid_s1 || push_ready);
	assign accept   = in_valid && in_ready;

	// map write: clearing sweep after reset, then modified tiles
	always_comb begin
		map_we = 1'b0;
		map_wa = tile_index[MAP_AW-1:0];
		map_wd = word_vis;
		if (clear_q) begin
			map_we = 1'b1;
			map_wa = clr_cnt_q;
			map_wd = 1'b0;
		end else if (accept && modified && in_range) begin
			map_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_q[map_wa] <= map_wd;
		end
		if (accept && in_range) begin
			rd_q <= map_q[tile_index[MAP_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q   <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clear_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == CLR_LAST) begin
				clear_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1     <= tile_index;
			mod_s1     <= modified;
			newp_s1    <= new_pass;
			wvis_s1    <= word_vis;
			inrange_s1 <= in_range;
			words_s1   <= {char_word_three, char_word_two, char_word_one, char_word_zero};
		end
	end

	always_comb begin
		found_eff = found_q && !newp_s1;
		vis       = mod_s1 ? wvis_s1 : (rd_q && inrange_s1);
		found_nxt = found_eff;
		bidx_nxt  = bidx_q;
		if (!found_eff && !vis) begin
			found_nxt = 1'b1;
			bidx_nxt  = idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			bidx_q  <= '0;
		end else if (push) begin
			found_q <= found_nxt;
			bidx_q  <= bidx_nxt;
		end
	end

	always_comb begin
		push_valid         = valid_s1;
		push_data.base     = {~idx_s1[10:5], idx_s1[4:0], 5'b00000};
		push_data.modified = mod_s1;
		push_data.vis      = vis;
		push_data.blank    = found_nxt ? {1'b0, bidx_nxt} : BLANK_NONE;
		push_data.words    = words_s1;
	end

endmodule

### hdl/ptr4c_fifo.sv
// Two-entry request queue between front and back.
module ptr4c_fifo import ptr4c_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  qent_t push_data,
	output logic  pop_valid,
	input  logic  pop_ready,
	output qent_t pop_data
);

	qent_t       ent_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        do_push;
	logic        do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = ent_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hdl/ptr4c_back.sv
// Back end: queued requests to texture words, one per cycle if out_ready.
module ptr4c_back import ptr4c_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  palette_t                   pal,
	input  logic                       head_valid,
	output logic                       head_pop,
	input  qent_t                      head,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [ADDR_W-1:0]          texture_word_address,
	output logic [WORD_W-1:0]          pixel_pair,
	output logic                       written,
	output logic                       tile_visible,
	output logic signed [BLANK_W-1:0]  blank_tile,
	output logic                       last
);

	logic [KCNT_W-1:0] k_q;
	logic              valid_q;
	logic              load;
	logic              last_word;
	logic [WORD_W-1:0] wa;
	logic [WORD_W-1:0] wb;
	logic [WORD_W-1:0] wx;
	logic [WORD_W-1:0] xs;
	logic [3:0]        shamt;
	logic [1:0]        lc;
	logic [1:0]        rc;
	logic [WORD_W-1:0] pair;

	assign last_word = !head.modified || (k_q == KCNT_LAST);
	assign load      = head_valid && (!valid_q || out_ready);
	assign head_pop  = load && last_word;
	assign out_valid = valid_q;

	// square order: word pair by k[4], A/B by k[2], shift 8 by k[3], 4 by k[1]
	always_comb begin
		wa    = k_q[4] ? head.words[1] : head.words[3];
		wb    = k_q[4] ? head.words[0] : head.words[2];
		wx    = k_q[2] ? wb : wa;
		shamt = {k_q[3], k_q[1], 2'b00};
		xs    = wx >> shamt;
		lc    = k_q[0] ? xs[1:0] : xs[17:16];
		rc    = k_q[0] ? xs[3:2] : xs[19:18];
		pair  = {color_of(rc, pal), color_of(lc, pal)};
		if (!(head.vis && head.modified)) begin
			pair = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				k_q     <= last_word ? '0 : k_q + 1'b1;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			texture_word_address <= {head.base[ADDR_W-1:KCNT_W], k_q};
			pixel_pair           <= pair;
			written              <= head.modified;
			tile_visible         <= head.vis;
			blank_tile           <= head.blank;
			last                 <= last_word;
		end
	end

endmodule

### hdl/planar_tile_to_rgba4_converter.sv
// Top level: converts two-bit character tiles into RGBA4 texture words.
// A tile passes the front register, the queue and the output registers before it shows.
// Unmodified tile: one word; modified tile: 32 words, one a cycle while out_ready is high.
// Reset: the visibility map is cleared for NUM_TILES cycles, during which in_ready is low.
// Reset colors are 0x00ff, 0x0f0f, 0xf00f; no blank tile recorded.
`include "planar_tile_to_rgba4_converter_macros.svh"
module planar_tile_to_rgba4_converter import ptr4c_pkg::*; #(
	parameter int unsigned NUM_TILES = 2048
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [COLOR_W-1:0]         cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [IDX_W-1:0]           tile_index,
	input  logic                       modified,
	input  logic                       new_pass,
	input  logic [WORD_W-1:0]          char_word_zero,
	input  logic [WORD_W-1:0]          char_word_one,
	input  logic [WORD_W-1:0]          char_word_two,
	input  logic [WORD_W-1:0]          char_word_three,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [ADDR_W-1:0]          texture_word_address,
	output logic [WORD_W-1:0]          pixel_pair,
	output logic                       written,
	output logic                       tile_visible,
	output logic signed [BLANK_W-1:0]  blank_tile,
	output logic                       last
);

	palette_t pal_q;
	logic     q_push_valid;
	logic     q_push_ready;
	qent_t    q_push_data;
	logic     q_pop_valid;
	logic     q_pop_ready;
	qent_t    q_pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_q.one   <= COLOR_ONE_RST;
			pal_q.two   <= COLOR_TWO_RST;
			pal_q.three <= COLOR_THREE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_COLOR_ONE:   pal_q.one   <= cfg_data;
				CFG_COLOR_TWO:   pal_q.two   <= cfg_data;
				CFG_COLOR_THREE: pal_q.three <= cfg_data;
				default:         pal_q       <= pal_q;
			endcase
		end
	end

	ptr4c_front #(
		.NUM_TILES(NUM_TILES)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.tile_index      (tile_index),
		.modified        (modified),
		.new_pass        (new_pass),
		.char_word_zero  (char_word_zero),
		.char_word_one   (char_word_one),
		.char_word_two   (char_word_two),
		.char_word_three (char_word_three),
		.push_valid      (q_push_valid),
		.push_ready      (q_push_ready),
		.push_data       (q_push_data)
	);

	ptr4c_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_data   (q_pop_data)
	);

	ptr4c_back u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.pal                  (pal_q),
		.head_valid           (q_pop_valid),
		.head_pop             (q_pop_ready),
		.head                 (q_pop_data),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.texture_word_address (texture_word_address),
		.pixel_pair           (pixel_pair),
		.written              (written),
		.tile_visible         (tile_visible),
		.blank_tile           (blank_tile),
		.last                 (last)
	);

	`PTR4C_ASSERT_IMPLY(a_status_single, out_valid && !written, last)
	`PTR4C_ASSERT_IMPLY(a_blank_zero, out_valid && written && !tile_visible, pixel_pair == '0)
	`PTR4C_ASSERT_IMPLY(a_blank_field, out_valid, !blank_tile[11] || blank_tile == BLANK_NONE)
	`PTR4C_ASSERT_NEXT(a_burst_gapless, out_valid && out_ready && !last, out_valid)

endmodule

### bench/planar_tile_to_rgba4_converter_test.sv
// Self-checking bench for the tile to RGBA4 converter: tiles against a texel prediction.
`timescale 1ns / 100ps
module planar_tile_to_rgba4_converter_test;
	import ptr4c_pkg::*;

	localparam int unsigned NUM_TILES = 2048;
	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam logic [WORD_W-1:0] CODE_PAIR_MASK = 32'h0003_0003;
	localparam int RANDOM_ITEMS = 448;
	localparam int PHASES = 4;

	typedef struct packed {
		logic [IDX_W-1:0]       idx;
		logic                   modified;
		logic                   new_pass;
		logic [3:0][WORD_W-1:0] words;
	} tile_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [WORD_W-1:0]  pair;
		logic               written;
		logic               vis;
		logic [BLANK_W-1:0] blank;
		logic               last;
	} texel_t;

	class texel_scoreboard;
		palette_t pal;
		bit vis_map [NUM_TILES];
		bit blank_found;
		logic [IDX_W-1:0] blank_idx;
		texel_t texel_q[$];
		int errors;

		function new();
			pal.one = COLOR_ONE_RST;
			pal.two = COLOR_TWO_RST;
			pal.three = COLOR_THREE_RST;
			foreach (vis_map[i])
				vis_map[i] = 1'b0;
			blank_found = 1'b0;
			blank_idx = '0;
			errors = 0;
		endfunction

		function void set_color(logic [1:0] index, logic [COLOR_W-1:0] value);
			case (index)
				CFG_COLOR_ONE:   pal.one = value;
				CFG_COLOR_TWO:   pal.two = value;
				CFG_COLOR_THREE: pal.three = value;
				default: ;
			endcase
		endfunction

		function logic [COLOR_W-1:0] rgba_of(logic [1:0] code);
			case (code)
				PIX_ONE:   return pal.one;
				PIX_TWO:   return pal.two;
				PIX_THREE: return pal.three;
				default:   return '0;
			endcase
		endfunction

		function logic [BLANK_W-1:0] blank_now();
			return blank_found ? {1'b0, blank_idx} : BLANK_NONE;
		endfunction

		function void note_tile(tile_t t);
			logic [ADDR_W-1:0] base;
			logic [WORD_W-1:0] x, l, r, a, b;
			logic [3:0] sq;
			int s;
			bit vis;
			texel_t e;
			if (t.new_pass)
				blank_found = 1'b0;
			base = {6'd63 - t.idx[10:5], t.idx[4:0], 5'd0};
			if (!t.modified) begin
				vis = vis_map[t.idx];
				if (!blank_found && !vis) begin
					blank_found = 1'b1;
					blank_idx = t.idx;
				end
				e = '{addr: base, pair: '0, written: 1'b0, vis: vis, blank: blank_now(),
					last: 1'b1};
				texel_q.push_back(e);
				return;
			end
			vis = |t.words;
			vis_map[t.idx] = vis;
			if (!vis && !blank_found) begin
				blank_found = 1'b1;
				blank_idx = t.idx;
			end
			for (int k = 0; k < 32; k++) begin
				e = '{addr: base + ADDR_W'(k), pair: '0, written: 1'b1, vis: vis,
					blank: blank_now(), last: (k == 31)};
				if (vis) begin
					a = k[4] ? t.words[1] : t.words[3];
					b = k[4] ? t.words[0] : t.words[2];
					sq = {1'b0, k[3:1]};
					x = sq[1] ? b : a;
					s = sq[2] * 8 + sq[0] * 4;
					l = (x >> s) & CODE_PAIR_MASK;
					r = (x >> (s + 2)) & CODE_PAIR_MASK;
					if (k[0])
						e.pair = {rgba_of(r[1:0]), rgba_of(l[1:0])};
					else
						e.pair = {rgba_of(r[17:16]), rgba_of(l[17:16])};
				end
				texel_q.push_back(e);
			end
		endfunction

		function void check_word(texel_t got);
			texel_t want;
			if (texel_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected texel: addr=%h pair=%h wr=%b vis=%b blank=%h last=%b",
						got.addr, got.pair, got.written, got.vis, got.blank, got.last);
				return;
			end
			want = texel_q.pop_front();
			if (got.addr !== want.addr || got.pair !== want.pair ||
					got.written !== want.written || got.vis !== want.vis ||
					got.blank !== want.blank || got.last !== want.last) begin
				errors++;
				if (errors <= 10)
					$display("texel error: exp addr=%h pair=%h wr=%b vis=%b blank=%h last=%b %s",
						want.addr, want.pair, want.written, want.vis, want.blank, want.last,
						$sformatf("got addr=%h pair=%h wr=%b vis=%b blank=%h last=%b",
						got.addr, got.pair, got.written, got.vis, got.blank, got.last));
			end
		endfunction

		function int pending();
			return texel_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [COLOR_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [IDX_W-1:0] tile_index;
	logic modified;
	logic new_pass;
	logic [WORD_W-1:0] char_word_zero;
	logic [WORD_W-1:0] char_word_one;
	logic [WORD_W-1:0] char_word_two;
	logic [WORD_W-1:0] char_word_three;
	logic out_valid;
	logic out_ready;
	logic [ADDR_W-1:0] texture_word_address;
	logic [WORD_W-1:0] pixel_pair;
	logic written;
	logic tile_visible;
	logic signed [BLANK_W-1:0] blank_tile;
	logic last;

	texel_scoreboard sb;
	bit src_idle;
	bit sink_idle;
	int hold_cycles;

	planar_tile_to_rgba4_converter #(.NUM_TILES(NUM_TILES)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.tile_index(tile_index),
		.modified(modified),
		.new_pass(new_pass),
		.char_word_zero(char_word_zero),
		.char_word_one(char_word_one),
		.char_word_two(char_word_two),
		.char_word_three(char_word_three),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.texture_word_address(texture_word_address),
		.pixel_pair(pixel_pair),
		.written(written),
		.tile_visible(tile_visible),
		.blank_tile(blank_tile),
		.last(last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int draw_gap(bit on);
		if (!on || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 19);
	endfunction

	function automatic tile_t mk_tile(int idx, bit is_mod, bit np, logic [WORD_W-1:0] w0,
			logic [WORD_W-1:0] w1, logic [WORD_W-1:0] w2, logic [WORD_W-1:0] w3);
		tile_t t;
		t.idx = IDX_W'(idx);
		t.modified = is_mod;
		t.new_pass = np;
		t.words = {w3, w2, w1, w0};
		return t;
	endfunction

	function automatic tile_t rand_tile(int idx, bit np);
		tile_t t;
		int pick;
		t = mk_tile(idx, $urandom_range(0, 9) < 6, np, $urandom, $urandom, $urandom, $urandom);
		pick = $urandom_range(0, 7);
		if (pick < 2) begin
			t.words = '0;
		end else if (pick == 2) begin
			t.words = '0;
			t.words[$urandom_range(0, 3)] = WORD_W'(1) << $urandom_range(0, 31);
		end
		return t;
	endfunction

	task automatic send_tile(tile_t t);
		int gap;
		gap = draw_gap(src_idle);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		tile_index = t.idx;
		modified = t.modified;
		new_pass = t.new_pass;
		{char_word_three, char_word_two, char_word_one, char_word_zero} = t.words;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_tile(t);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] index, logic [COLOR_W-1:0] value);
		cfg_index = index;
		cfg_data = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_color(index, value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic write_palette(logic [COLOR_W-1:0] c1, logic [COLOR_W-1:0] c2,
			logic [COLOR_W-1:0] c3);
		write_reg(CFG_COLOR_ONE, c1);
		write_reg(CFG_COLOR_TWO, c2);
		write_reg(CFG_COLOR_THREE, c3);
	endtask

	// one ascending pass of tiles, or now and then a stray request
	task automatic run_pass(output int n);
		int len;
		int step;
		int idx;
		if ($urandom_range(0, 9) == 0) begin
			send_tile(rand_tile($urandom_range(0, NUM_TILES - 1), 1'($urandom_range(0, 1))));
			n = 1;
		end else begin
			len = $urandom_range(2, 10);
			step = $urandom_range(1, 3);
			if ($urandom_range(0, 3) == 0)
				idx = $urandom_range(0, NUM_TILES - 1 - len * step);
			else
				idx = $urandom_range(0, 48);
			for (int k = 0; k < len; k++) begin
				send_tile(rand_tile(idx, k == 0));
				idx += step;
			end
			n = len;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_word('{addr: texture_word_address, pair: pixel_pair, written: written,
				vis: tile_visible, blank: blank_tile, last: last});
	end

	initial begin : sink
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_cycles != 0) begin
				out_ready = 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end
			gap = draw_gap(sink_idle);
			if (gap != 0) begin
				out_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	initial begin
		#20_000_000;
		$display("planar_tile_to_rgba4_converter: mismatch");
		$finish;
	end

	initial begin
		int sent;
		int n;
		sb = new();
		src_idle = 1'b1;
		sink_idle = 1'b1;
		hold_cycles = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_COLOR_ONE;
		cfg_data = '0;
		in_valid = 1'b0;
		tile_index = '0;
		modified = 1'b0;
		new_pass = 1'b0;
		char_word_zero = '0;
		char_word_one = '0;
		char_word_two = '0;
		char_word_three = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset palette, blank tracking, map read-back, index extremes
		send_tile(mk_tile(0, 0, 1, 0, 0, 0, 0));
		send_tile(mk_tile(1, 1, 0, '1, '1, '1, '1));
		send_tile(mk_tile(2, 1, 0, 0, 0, 0, 0));
		send_tile(mk_tile(3, 1, 0, 32'h1b1b_e4e4, 32'h55aa_33cc, 32'h0f0f_f0f0,
			32'h8421_1248));
		send_tile(mk_tile(1, 0, 0, 0, 0, 0, 0));
		send_tile(mk_tile(2, 0, 0, '1, '1, '1, '1));
		send_tile(mk_tile(5, 1, 1, 0, 0, 0, 32'h1));
		send_tile(mk_tile(6, 0, 0, 0, 0, 0, 0));
		send_tile(mk_tile(2047, 1, 0, 32'h8000_0000, 0, 0, 0));
		send_tile(mk_tile(2047, 0, 1, 0, 0, 0, 0));
		send_tile(mk_tile(2047, 1, 1, 0, 0, 0, 0));
		send_tile(mk_tile(2047, 0, 0, '1, 0, '1, 0));
		send_tile(mk_tile(1024, 1, 1, 32'hdead_beef, 32'h0123_4567, 32'h89ab_cdef,
			32'hfedc_ba98));
		send_tile(mk_tile(1024, 0, 0, 0, 0, 0, 0));
		drain();
		write_palette(16'h0000, 16'hffff, 16'h0000);
		send_tile(mk_tile(3, 1, 1, 32'h1b1b_e4e4, 32'h55aa_33cc, 32'h0f0f_f0f0,
			32'h8421_1248));
		send_tile(mk_tile(4, 1, 0, '1, '1, '1, '1));
		drain();
		write_palette(16'hffff, 16'h0000, 16'hffff);
		write_reg(CFG_SPARE, 16'h1234);
		send_tile(mk_tile(3, 1, 1, 32'h1b1b_e4e4, 32'h55aa_33cc, 32'h0f0f_f0f0,
			32'h8421_1248));
		send_tile(mk_tile(4, 0, 0, 0, 0, 0, 0));
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: write_palette(16'hffff, 16'h0000, 16'hffff);
				2: write_palette(16'h0000, 16'hffff, 16'h0000);
				default: begin
					write_palette(COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
					write_reg(CFG_SPARE, COLOR_W'($urandom));
				end
			endcase
			src_idle = (p != 1) && (p != 3);
			sink_idle = (p != 1) && (p != 2);
			if (p == 1)
				hold_cycles = 400;
			sent = 0;
			while (sent < RANDOM_ITEMS / PHASES) begin
				run_pass(n);
				sent += n;
				if (p == 2 && sent >= RANDOM_ITEMS / (2 * PHASES) &&
						sent - n < RANDOM_ITEMS / (2 * PHASES)) begin
					in_valid = 1'b0;
					while (sb.pending() != 0)
						@(negedge clk);
				end
			end
			drain();
		end

		repeat (16) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("planar_tile_to_rgba4_converter: match");
		else
			$display("planar_tile_to_rgba4_converter: mismatch");
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/ptr4c_pkg.sv
hdl/ptr4c_front.sv
hdl/ptr4c_fifo.sv
hdl/ptr4c_back.sv
hdl/planar_tile_to_rgba4_converter.sv
bench/planar_tile_to_rgba4_converter_test.sv
